// ===== rtl/fts_pkg.sv =====
// Shared constants, types and helper functions for the flat triangle shading block.
// Holds the field widths, the block-scaling helpers and the intensity table.
// No dependencies.
package fts_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int IDX_BITS = 8;
    localparam int INTENSITY_TABLE_DEPTH = 1 << IDX_BITS;

    localparam int EDGE_BITS = 30;
    localparam int VEC_BITS = 12;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int EDGE_W = EDGE_BITS + 1;
    localparam int NORM_W = 2 * EDGE_W;
    localparam int VEC_W = VEC_BITS + 1;
    localparam int DOT_W = 2 * VEC_BITS + 3;
    localparam int SQ_W = 2 * VEC_BITS + 2;
    localparam int DMAG_W = DOT_W - 1;
    localparam int DEN_W = 2 * SQ_W;
    localparam int COLOR_W = 32;
    localparam int CHAN_W = 8;
    localparam int Q15_W = 16;
    localparam int Q15_FRAC = 15;
    localparam int MAG_W = 64;
    localparam int LEN_W = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [Q15_W-1:0] FLOOR_Q15 = 16'd22938;

    localparam logic [CFG_IDX_W-1:0] REG_CAM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_Z = 2'd2;

    typedef logic [MAG_W-1:0] mag_t;
    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [INTENSITY_TABLE_DEPTH-1:0][Q15_W-1:0] rom_t;

    // Bit length of a magnitude: position of the highest set bit plus one.
    function automatic logic [LEN_W-1:0] bit_len(mag_t x);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (x[i])
            begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

    // Shift a magnitude by the amount that brings the whole vector below 2^bits.
    // The OR of all magnitudes has the same bit length as their maximum.
    function automatic mag_t scale_mag(mag_t m, mag_t orv, int bits);
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] s;
        len = bit_len(orv);
        s = (len > LEN_W'(bits)) ? len - LEN_W'(bits) : '0;
        return m >> s;
    endfunction

    function automatic logic [31:0] pow10_q15(logic [31:0] y);
        logic [31:0] y2;
        logic [31:0] y4;
        logic [31:0] y8;
        logic [31:0] p;
        y2 = (y * y) >> Q15_FRAC;
        y4 = (y2 * y2) >> Q15_FRAC;
        y8 = (y4 * y4) >> Q15_FRAC;
        p = (y8 * y2) >> Q15_FRAC;
        return p;
    endfunction

    // Entry i is the largest y in Q1.15 whose tenth power does not exceed i/DEPTH.
    function automatic rom_t build_rom();
        rom_t r;
        logic [31:0] t;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        for (int i = 0; i < INTENSITY_TABLE_DEPTH; i++)
        begin
            t = 32'((i * 32768) / INTENSITY_TABLE_DEPTH);
            lo = 32'd0;
            hi = 32'd32768;
            for (int k = 0; k < 17; k++)
            begin
                if (lo < hi)
                begin
                    mid = (lo + hi + 32'd1) >> 1;
                    if (pow10_q15(mid) <= t)
                    begin
                        lo = mid;
                    end
                    else
                    begin
                        hi = mid - 32'd1;
                    end
                end
            end
            r[i] = lo[Q15_W-1:0];
        end
        return r;
    endfunction

    localparam rom_t INTENSITY_ROM = build_rom();

endpackage

// ===== rtl/fts_geom.sv =====
// Geometry front end: edges, light vector, block scaling and face normal cross product.
// Seven register stages. Depends on fts_pkg.
module fts_geom (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [fts_pkg::COLOR_W-1:0]   in_color,
    input  fts_pkg::coord_t               v0 [3],
    input  fts_pkg::coord_t               v1 [3],
    input  fts_pkg::coord_t               v2 [3],
    input  fts_pkg::coord_t               cam [3],
    output logic                          out_valid,
    output logic [fts_pkg::COLOR_W-1:0]   out_color,
    output fts_pkg::vec_t                 n_vec [3],
    output fts_pkg::vec_t                 l_vec [3]
);
    import fts_pkg::*;

    localparam int STAGES = 7;
    localparam int LDLY = 4;

    logic [STAGES-1:0] valid_reg;
    logic [COLOR_W-1:0] color_reg [STAGES];

    // Stage 1: exact differences.
    logic signed [DIFF_W-1:0] e1_reg [3];
    logic signed [DIFF_W-1:0] e2_reg [3];
    logic signed [DIFF_W-1:0] ld_reg [3];
    // Stage 2: magnitudes and signs.
    logic [DIFF_W-1:0] e1m_reg [3];
    logic [DIFF_W-1:0] e2m_reg [3];
    logic [DIFF_W-1:0] lm_reg [3];
    logic [2:0] e1s_reg;
    logic [2:0] e2s_reg;
    logic [2:0] ls_reg;
    // Stage 3: scaled edges and light.
    logic signed [EDGE_W-1:0] e1k_reg [3];
    logic signed [EDGE_W-1:0] e2k_reg [3];
    vec_t lk_reg [LDLY+1][3];
    // Stage 4: cross product terms.
    logic signed [NORM_W-1:0] p_reg [6];
    // Stage 5: raw normal.
    logic signed [NORM_W-1:0] n_reg [3];
    // Stage 6: normal magnitudes.
    logic [NORM_W-1:0] nm_reg [3];
    logic [2:0] ns_reg;
    // Stage 7: scaled normal.
    vec_t nk_reg [3];

    logic signed [DIFF_W-1:0] e1_next [3];
    logic signed [DIFF_W-1:0] e2_next [3];
    logic signed [DIFF_W-1:0] ld_next [3];
    logic [DIFF_W-1:0] e1m_next [3];
    logic [DIFF_W-1:0] e2m_next [3];
    logic [DIFF_W-1:0] lm_next [3];
    logic signed [EDGE_W-1:0] e1k_next [3];
    logic signed [EDGE_W-1:0] e2k_next [3];
    vec_t lk_next [3];
    logic signed [NORM_W-1:0] p_next [6];
    logic signed [NORM_W-1:0] n_next [3];
    logic [NORM_W-1:0] nm_next [3];
    vec_t nk_next [3];
    mag_t e1_or;
    mag_t e2_or;
    mag_t l_or;
    mag_t n_or;
    mag_t sm;
    logic signed [EDGE_W-1:0] se;
    vec_t sv;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e1_next[k] = {v1[k][COORD_WIDTH-1], v1[k]} - {v0[k][COORD_WIDTH-1], v0[k]};
            e2_next[k] = {v2[k][COORD_WIDTH-1], v2[k]} - {v0[k][COORD_WIDTH-1], v0[k]};
            ld_next[k] = {cam[k][COORD_WIDTH-1], cam[k]} - {v0[k][COORD_WIDTH-1], v0[k]};
            e1m_next[k] = e1_reg[k][DIFF_W-1] ? DIFF_W'(-e1_reg[k]) : DIFF_W'(e1_reg[k]);
            e2m_next[k] = e2_reg[k][DIFF_W-1] ? DIFF_W'(-e2_reg[k]) : DIFF_W'(e2_reg[k]);
            lm_next[k] = ld_reg[k][DIFF_W-1] ? DIFF_W'(-ld_reg[k]) : DIFF_W'(ld_reg[k]);
        end

        e1_or = MAG_W'(e1m_reg[0] | e1m_reg[1] | e1m_reg[2]);
        e2_or = MAG_W'(e2m_reg[0] | e2m_reg[1] | e2m_reg[2]);
        l_or = MAG_W'(lm_reg[0] | lm_reg[1] | lm_reg[2]);
        n_or = MAG_W'(nm_reg[0] | nm_reg[1] | nm_reg[2]);

        for (int k = 0; k < 3; k++)
        begin
            sm = scale_mag(MAG_W'(e1m_reg[k]), e1_or, EDGE_BITS);
            se = EDGE_W'(sm);
            e1k_next[k] = e1s_reg[k] ? -se : se;
            sm = scale_mag(MAG_W'(e2m_reg[k]), e2_or, EDGE_BITS);
            se = EDGE_W'(sm);
            e2k_next[k] = e2s_reg[k] ? -se : se;
            sm = scale_mag(MAG_W'(lm_reg[k]), l_or, VEC_BITS);
            sv = VEC_W'(sm);
            lk_next[k] = ls_reg[k] ? -sv : sv;
            sm = scale_mag(MAG_W'(nm_reg[k]), n_or, VEC_BITS);
            sv = VEC_W'(sm);
            nk_next[k] = ns_reg[k] ? -sv : sv;
            nm_next[k] = n_reg[k][NORM_W-1] ? NORM_W'(-n_reg[k]) : NORM_W'(n_reg[k]);
        end

        p_next[0] = e1k_reg[1] * e2k_reg[2];
        p_next[1] = e1k_reg[2] * e2k_reg[1];
        p_next[2] = e1k_reg[2] * e2k_reg[0];
        p_next[3] = e1k_reg[0] * e2k_reg[2];
        p_next[4] = e1k_reg[0] * e2k_reg[1];
        p_next[5] = e1k_reg[1] * e2k_reg[0];

        n_next[0] = p_reg[0] - p_reg[1];
        n_next[1] = p_reg[2] - p_reg[3];
        n_next[2] = p_reg[4] - p_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg[0] <= in_color;
        for (int s = 1; s < STAGES; s++)
        begin
            color_reg[s] <= color_reg[s-1];
        end
        for (int k = 0; k < 3; k++)
        begin
            e1_reg[k] <= e1_next[k];
            e2_reg[k] <= e2_next[k];
            ld_reg[k] <= ld_next[k];
            e1m_reg[k] <= e1m_next[k];
            e2m_reg[k] <= e2m_next[k];
            lm_reg[k] <= lm_next[k];
            e1s_reg[k] <= e1_reg[k][DIFF_W-1];
            e2s_reg[k] <= e2_reg[k][DIFF_W-1];
            ls_reg[k] <= ld_reg[k][DIFF_W-1];
            e1k_reg[k] <= e1k_next[k];
            e2k_reg[k] <= e2k_next[k];
            lk_reg[0][k] <= lk_next[k];
            for (int s = 1; s <= LDLY; s++)
            begin
                lk_reg[s][k] <= lk_reg[s-1][k];
            end
            n_reg[k] <= n_next[k];
            nm_reg[k] <= nm_next[k];
            ns_reg[k] <= n_reg[k][NORM_W-1];
            nk_reg[k] <= nk_next[k];
        end
        for (int j = 0; j < 6; j++)
        begin
            p_reg[j] <= p_next[j];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_color = color_reg[STAGES-1];
    assign n_vec = nk_reg;
    assign l_vec = lk_reg[LDLY];

endmodule

// ===== rtl/fts_cos.sv =====
// Squared cosine to table index: dot products, products and a pipelined restoring divider.
// Computes floor(d*d*DEPTH / (n.n * l.l)) saturated to DEPTH-1, one quotient bit per stage.
// Depends on fts_pkg.
module fts_cos (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [fts_pkg::COLOR_W-1:0]   in_color,
    input  fts_pkg::vec_t                 n_vec [3],
    input  fts_pkg::vec_t                 l_vec [3],
    output logic                          out_valid,
    output logic [fts_pkg::COLOR_W-1:0]   out_color,
    output logic                          out_floor,
    output logic [fts_pkg::IDX_BITS-1:0]  out_idx
);
    import fts_pkg::*;

    localparam int FRONT = 4;
    localparam int DSTG = IDX_BITS + 1;
    localparam int STAGES = FRONT + DSTG;
    localparam int Q_W = IDX_BITS + 1;

    logic [STAGES-1:0] valid_reg;
    logic [COLOR_W-1:0] color_reg [STAGES];

    logic signed [DOT_W-1:0] dp_reg [3];
    logic signed [DOT_W-1:0] nsq_reg [3];
    logic signed [DOT_W-1:0] lsq_reg [3];
    logic signed [DOT_W-1:0] d_reg;
    logic [SQ_W-1:0] nn_reg;
    logic [SQ_W-1:0] ll_reg;
    logic [DMAG_W-1:0] dm_reg;
    logic [SQ_W-1:0] nn3_reg;
    logic [SQ_W-1:0] ll3_reg;
    logic [FRONT+DSTG-3:0] floor_reg;
    logic [DEN_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg [DSTG];
    logic [DEN_W-1:0] rem_reg [DSTG];
    logic [Q_W-1:0] q_reg [DSTG];

    logic signed [DOT_W-1:0] dp_next [3];
    logic signed [DOT_W-1:0] nsq_next [3];
    logic signed [DOT_W-1:0] lsq_next [3];
    logic [DEN_W:0] trial [DSTG];
    logic [DEN_W-1:0] rem_next [DSTG];
    logic [Q_W-1:0] q_next [DSTG];
    logic bit_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dp_next[k] = n_vec[k] * l_vec[k];
            nsq_next[k] = n_vec[k] * n_vec[k];
            lsq_next[k] = l_vec[k] * l_vec[k];
        end

        // The numerator never exceeds the denominator, so the top quotient
        // bit is set only when the two vectors are parallel, antiparallel or zero.
        for (int j = 0; j < DSTG; j++)
        begin
            if (j == 0)
            begin
                trial[j] = {1'b0, num_reg};
                q_next[j] = '0;
            end
            else
            begin
                trial[j] = {rem_reg[j-1], 1'b0};
                q_next[j] = {q_reg[j-1][Q_W-2:0], 1'b0};
            end
            bit_next = trial[j] >= {1'b0, den_reg[j]};
            q_next[j][0] = bit_next;
            rem_next[j] = bit_next ? DEN_W'(trial[j] - {1'b0, den_reg[j]}) : DEN_W'(trial[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg[0] <= in_color;
        for (int s = 1; s < STAGES; s++)
        begin
            color_reg[s] <= color_reg[s-1];
        end
        for (int k = 0; k < 3; k++)
        begin
            dp_reg[k] <= dp_next[k];
            nsq_reg[k] <= nsq_next[k];
            lsq_reg[k] <= lsq_next[k];
        end
        d_reg <= dp_reg[0] + dp_reg[1] + dp_reg[2];
        nn_reg <= SQ_W'(nsq_reg[0]) + SQ_W'(nsq_reg[1]) + SQ_W'(nsq_reg[2]);
        ll_reg <= SQ_W'(lsq_reg[0]) + SQ_W'(lsq_reg[1]) + SQ_W'(lsq_reg[2]);
        dm_reg <= d_reg[DOT_W-1] ? DMAG_W'(-d_reg) : DMAG_W'(d_reg);
        nn3_reg <= nn_reg;
        ll3_reg <= ll_reg;
        floor_reg[0] <= (nn_reg == '0) || (ll_reg == '0);
        for (int s = 1; s < FRONT + DSTG - 2; s++)
        begin
            floor_reg[s] <= floor_reg[s-1];
        end
        num_reg <= dm_reg * dm_reg;
        den_reg[0] <= nn3_reg * ll3_reg;
        for (int j = 1; j < DSTG; j++)
        begin
            den_reg[j] <= den_reg[j-1];
        end
        for (int j = 0; j < DSTG; j++)
        begin
            rem_reg[j] <= rem_next[j];
            q_reg[j] <= q_next[j];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_color = color_reg[STAGES-1];
    assign out_floor = floor_reg[FRONT+DSTG-3];
    assign out_idx = q_reg[DSTG-1][Q_W-1] ? '1 : q_reg[DSTG-1][IDX_BITS-1:0];

endmodule

// ===== rtl/fts_shade.sv =====
// Intensity lookup with the 0.7 floor, then scaling of the red, green and blue channels.
// Two register stages. Depends on fts_pkg.
module fts_shade (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [fts_pkg::COLOR_W-1:0]   in_color,
    input  logic                          in_floor,
    input  logic [fts_pkg::IDX_BITS-1:0]  in_idx,
    output logic                          out_valid,
    output logic [fts_pkg::CHAN_W-1:0]    out_red,
    output logic [fts_pkg::CHAN_W-1:0]    out_green,
    output logic [fts_pkg::CHAN_W-1:0]    out_blue,
    output logic [fts_pkg::CHAN_W-1:0]    out_alpha
);
    import fts_pkg::*;

    localparam int PRD_W = CHAN_W + Q15_W;

    logic [1:0] valid_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [Q15_W-1:0] inten_reg;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;
    logic [CHAN_W-1:0] alpha_reg;

    logic [Q15_W-1:0] entry;
    logic [Q15_W-1:0] inten_next;
    logic [PRD_W-1:0] red_prd;
    logic [PRD_W-1:0] green_prd;
    logic [PRD_W-1:0] blue_prd;

    always_comb
    begin
        entry = INTENSITY_ROM[in_idx];
        inten_next = (in_floor || entry < FLOOR_Q15) ? FLOOR_Q15 : entry;
        red_prd = color_reg[CHAN_W-1:0] * inten_reg;
        green_prd = color_reg[2*CHAN_W-1:CHAN_W] * inten_reg;
        blue_prd = color_reg[3*CHAN_W-1:2*CHAN_W] * inten_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg <= in_color;
        inten_reg <= inten_next;
        red_reg <= red_prd[Q15_FRAC+CHAN_W-1:Q15_FRAC];
        green_reg <= green_prd[Q15_FRAC+CHAN_W-1:Q15_FRAC];
        blue_reg <= blue_prd[Q15_FRAC+CHAN_W-1:Q15_FRAC];
        alpha_reg <= color_reg[4*CHAN_W-1:3*CHAN_W];
    end

    assign out_valid = valid_reg[1];
    assign out_red = red_reg;
    assign out_green = green_reg;
    assign out_blue = blue_reg;
    assign out_alpha = alpha_reg;

endmodule

// ===== rtl/flat_triangle_shading.sv =====
// Top level of the flat triangle shading block: camera registers and the three pipeline parts.
// Depends on fts_pkg, fts_geom, fts_cos and fts_shade.
//
// Usage: a triangle (three vertices in signed Q16.16 and a packed 0xAABBGGRR color) is
// taken at a rising edge where start is high and busy is low. busy is high only in the
// first cycle after reset is released; after that a new triangle may enter every cycle.
// Each shaded color is on the shaded_* ports for exactly one cycle with done high;
// results leave in the order the triangles came in. The depth is set by the geometry
// pipeline (7 stages), the dot product and product stages (4), the restoring divider
// that forms one index bit per stage (9) and the table lookup and color scaling (2).
// The receiver cannot stall the block, so the pipeline never holds and throughput is
// one triangle per cycle.
// The camera position is written through the cfg_* channel (index 0 x, 1 y, 2 z; other
// indexes are ignored); cfg_ready is always high. Write it only while no triangle is in
// flight. Reset clears the camera to the origin and empties the pipeline.
module flat_triangle_shading (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [fts_pkg::COORD_WIDTH-1:0] v0_x,
    input  logic signed [fts_pkg::COORD_WIDTH-1:0] v0_y,
    input  logic signed [fts_pkg::COORD_WIDTH-1:0] v0_z,
    input  logic signed [fts_pkg::COORD_WIDTH-1:0] v1_x,
    input  logic signed [fts_pkg::COORD_WIDTH-1:0] v1_y,
    input  logic signed [fts_pkg::COORD_WIDTH-1:0] v1_z,
    input  logic signed [fts_pkg::COORD_WIDTH-1:0] v2_x,
    input  logic signed [fts_pkg::COORD_WIDTH-1:0] v2_y,
    input  logic signed [fts_pkg::COORD_WIDTH-1:0] v2_z,
    input  logic [fts_pkg::COLOR_W-1:0]       face_color,
    output logic                              done,
    output logic [fts_pkg::CHAN_W-1:0]        shaded_red,
    output logic [fts_pkg::CHAN_W-1:0]        shaded_green,
    output logic [fts_pkg::CHAN_W-1:0]        shaded_blue,
    output logic [fts_pkg::CHAN_W-1:0]        shaded_alpha,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic signed [fts_pkg::COORD_WIDTH-1:0] cfg_data
);
    import fts_pkg::*;

    logic busy_reg;
    coord_t cam_reg [3];

    coord_t v0 [3];
    coord_t v1 [3];
    coord_t v2 [3];
    logic accept;

    logic geom_valid;
    logic [COLOR_W-1:0] geom_color;
    vec_t n_vec [3];
    vec_t l_vec [3];

    logic cos_valid;
    logic [COLOR_W-1:0] cos_color;
    logic cos_floor;
    logic [IDX_BITS-1:0] cos_idx;

    assign accept = start && !busy_reg;
    assign busy = busy_reg;
    assign cfg_ready = 1'b1;

    assign v0[0] = v0_x;
    assign v0[1] = v0_y;
    assign v0[2] = v0_z;
    assign v1[0] = v1_x;
    assign v1[1] = v1_y;
    assign v1[2] = v1_z;
    assign v2[0] = v2_x;
    assign v2[1] = v2_y;
    assign v2[2] = v2_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                cam_reg[k] <= '0;
            end
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CAM_X: cam_reg[0] <= cfg_data;
                    REG_CAM_Y: cam_reg[1] <= cfg_data;
                    REG_CAM_Z: cam_reg[2] <= cfg_data;
                    default:   ;
                endcase
            end
        end
    end

    fts_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_color  (face_color),
        .v0        (v0),
        .v1        (v1),
        .v2        (v2),
        .cam       (cam_reg),
        .out_valid (geom_valid),
        .out_color (geom_color),
        .n_vec     (n_vec),
        .l_vec     (l_vec)
    );

    fts_cos u_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_valid),
        .in_color  (geom_color),
        .n_vec     (n_vec),
        .l_vec     (l_vec),
        .out_valid (cos_valid),
        .out_color (cos_color),
        .out_floor (cos_floor),
        .out_idx   (cos_idx)
    );

    fts_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cos_valid),
        .in_color  (cos_color),
        .in_floor  (cos_floor),
        .in_idx    (cos_idx),
        .out_valid (done),
        .out_red   (shaded_red),
        .out_green (shaded_green),
        .out_blue  (shaded_blue),
        .out_alpha (shaded_alpha)
    );

endmodule
